// File: rtl/csq_pkg.sv
// Shared types, constants and the 5% quantile table for the chi-square fit unit.
// No dependencies.
`timescale 1ns / 1ps
package csq_pkg;

  localparam int DEF_MAX_CELLS        = 32;
  localparam int DEF_QUANTILE_ENTRIES = 20;
  localparam int DEF_COUNT_BITS       = 16;

  localparam int SAMPLE_W   = 8;
  localparam int MODE_W     = 1;
  localparam int PROB_W     = 16;
  localparam int TRIAL_W    = 8;
  localparam int CHI_W      = 32;
  localparam int CELLTOT_W  = 6;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int FRAC_W     = 16;
  localparam int Q_W        = PROB_W + 1;
  localparam int POW_W      = 33;
  localparam int PROD_W     = 66;
  localparam int FACT_W     = 10;
  localparam int DIFF_W     = 48;
  localparam int DIV_NUM_W  = 64;
  localparam int DIV_DEN_W  = 32;
  localparam int QUANT_DEPTH = 64;
  localparam int QIDX_W     = 6;
  localparam int QUANT_W    = 20;
  localparam int CMP_W      = 48;
  localparam int QUANT_SCALE = 10000;
  localparam int QUANT_ROUND = 5000;
  localparam int ROUND_HALF  = 32768;

  localparam logic [CHI_W-1:0] SAT32 = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROB  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIAL = 2'd2;

  localparam logic [STATUS_W-1:0] FIT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] FIT_FEW_CELLS = 2'd1;
  localparam logic [STATUS_W-1:0] FIT_RANGE     = 2'd2;
  localparam logic [STATUS_W-1:0] FIT_ZERO_EXP  = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [PROB_W-1:0]  prob;
    logic [TRIAL_W-1:0] trial;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SETTLE, ST_POW, ST_POW_RND, ST_E0, ST_E0_RND, ST_ECHK, ST_OBS,
    ST_TSTART, ST_TWAIT, ST_ACC, ST_MUL_F, ST_MUL_P, ST_ESTART, ST_EWAIT, ST_DONE
  } back_state_t;

  // 5% upper quantiles, df = 1..64, in 1/10000
  localparam logic [QUANT_W-1:0] QUANT_E4 [QUANT_DEPTH] = '{
    20'd38415,  20'd59915,  20'd78147,  20'd94877,  20'd110700, 20'd125920, 20'd140670,
    20'd155070, 20'd169190, 20'd183070, 20'd196750, 20'd210260, 20'd223620, 20'd236850,
    20'd249960, 20'd262960, 20'd275870, 20'd288690, 20'd301440, 20'd314100, 20'd326710,
    20'd339240, 20'd351720, 20'd364150, 20'd376520, 20'd388850, 20'd401130, 20'd413370,
    20'd425570, 20'd437730, 20'd449850, 20'd461940, 20'd474000, 20'd486020, 20'd498020,
    20'd509980, 20'd521920, 20'd533840, 20'd545720, 20'd557580, 20'd569420, 20'd581240,
    20'd593040, 20'd604810, 20'd616560, 20'd628300, 20'd640010, 20'd651710, 20'd663390,
    20'd675050, 20'd686690, 20'd698320, 20'd709930, 20'd721530, 20'd733110, 20'd744680,
    20'd756240, 20'd767780, 20'd779310, 20'd790820, 20'd802320, 20'd813810, 20'd825290,
    20'd836750
  };

endpackage

// File: rtl/csq_if.sv
// Valid/ready channel interfaces for samples in and test results out.
// Depends on csq_pkg.
`timescale 1ns / 1ps
interface csq_in_if import csq_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_value;
  logic                last_sample;
  modport source(output valid, sample_value, last_sample, input ready);
  modport sink(input valid, sample_value, last_sample, output ready);
endinterface

interface csq_out_if import csq_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 test_pass;
  logic [CHI_W-1:0]     chi_statistic;
  logic [CELLTOT_W-1:0] cell_total;
  logic [STATUS_W-1:0]  fit_status;
  modport source(output valid, test_pass, chi_statistic, cell_total, fit_status, input ready);
  modport sink(input valid, test_pass, chi_statistic, cell_total, fit_status, output ready);
endinterface

// File: rtl/csq_ram.sv
// Generic single-write, single-read RAM with registered read (old data on collision).
// No dependencies.
`timescale 1ns / 1ps
module csq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/csq_fifo.sv
// Short queue between the sample front end and the histogram/evaluation back end.
// No dependencies.
`timescale 1ns / 1ps
module csq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr, rptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end
endmodule

// File: rtl/csq_front.sv
// Front end: accepts samples, range-checks them, tracks largest sample and count,
// and queues one entry per item. Depends on csq_pkg and csq_if.
`timescale 1ns / 1ps
module csq_front import csq_pkg::*; #(
  parameter int MAX_CELLS  = DEF_MAX_CELLS,
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  localparam int CIDX    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1,
  localparam int ENTRY_W = 2 * CIDX + COUNT_BITS + 3
) (
  input  logic               clk,
  input  logic               rst,
  csq_in_if.sink             in_ch,
  output logic               push,
  output logic [ENTRY_W-1:0] push_data,
  input  logic               full
);
  logic [CIDX-1:0]       largest, largest_next;
  logic [COUNT_BITS-1:0] n_samp, n_samp_next;
  logic                  rerr, rerr_next;
  logic                  in_range;
  logic [CIDX-1:0]       cell_idx;

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  always_comb begin
    in_range     = (int'(in_ch.sample_value) < MAX_CELLS);
    cell_idx     = CIDX'(in_ch.sample_value);
    largest_next = (in_range && (cell_idx > largest)) ? cell_idx : largest;
    n_samp_next  = (&n_samp) ? n_samp : n_samp + 1'b1;
    rerr_next    = rerr || !in_range;
    push_data    = {cell_idx, in_range, in_ch.last_sample, largest_next, n_samp_next,
                    rerr_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      largest <= '0;
      n_samp  <= '0;
      rerr    <= 1'b0;
    end else if (push) begin
      if (in_ch.last_sample) begin
        largest <= '0;
        n_samp  <= '0;
        rerr    <= 1'b0;
      end else begin
        largest <= largest_next;
        n_samp  <= n_samp_next;
        rerr    <= rerr_next;
      end
    end
  end
endmodule

// File: rtl/csq_div.sv
// Restoring divider, one quotient bit per cycle, result rounded half up.
// Depends on csq_pkg.
`timescale 1ns / 1ps
module csq_div import csq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic [DIV_NUM_W-1:0] num_sh, quo_acc;
  logic [DIV_DEN_W-1:0] den_r, rem, rem_nx;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 ge, rnd, run, fin;
  logic [CNT_W-1:0]     cnt;

  always_comb begin
    rem_sh = {rem, num_sh[DIV_NUM_W-1]};
    ge     = (rem_sh >= {1'b0, den_r});
    rem_nx = ge ? DIV_DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_DEN_W-1:0];
    rnd    = ({rem, 1'b0} >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        fin <= 1'b0;
      end else if (run) begin
        if (cnt == CNT_W'(DIV_NUM_W - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh  <= num;
      den_r   <= den;
      rem     <= '0;
      quo_acc <= '0;
      cnt     <= '0;
    end else if (run) begin
      num_sh  <= {num_sh[DIV_NUM_W-2:0], 1'b0};
      rem     <= rem_nx;
      quo_acc <= {quo_acc[DIV_NUM_W-2:0], ge};
      cnt     <= cnt + 1'b1;
    end else if (fin) begin
      quo <= quo_acc + DIV_NUM_W'(rnd);
    end
  end
endmodule

// File: rtl/csq_back.sv
// Back end: histogram update from the queue, then per-set evaluation of expected
// counts and the chi-square sum. Depends on csq_pkg, csq_if, csq_ram, csq_div.
`timescale 1ns / 1ps
module csq_back import csq_pkg::*; #(
  parameter int MAX_CELLS        = DEF_MAX_CELLS,
  parameter int QUANTILE_ENTRIES = DEF_QUANTILE_ENTRIES,
  parameter int COUNT_BITS       = DEF_COUNT_BITS,
  localparam int CIDX    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1,
  localparam int CW      = CIDX + 1,
  localparam int ENTRY_W = 2 * CIDX + COUNT_BITS + 3
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               q_empty,
  input  logic [ENTRY_W-1:0] q_data,
  output logic               q_pop,
  csq_out_if.source          out_ch
);
  back_state_t state, state_next;

  logic [CIDX-1:0]       e_cell, e_largest;
  logic                  e_inr, e_last, e_rerr;
  logic [COUNT_BITS-1:0] e_n;

  logic                  b_valid, b_inr, b_last, b_rerr;
  logic [CIDX-1:0]       b_cell, b_largest;
  logic [COUNT_BITS-1:0] b_n;
  logic                  fwd_valid;
  logic [CIDX-1:0]       fwd_addr;
  logic [COUNT_BITS-1:0] fwd_data;
  logic [MAX_CELLS-1:0]  cnt_valid;

  logic [CIDX-1:0]       largest, i;
  logic [COUNT_BITS-1:0] n_samp;
  logic                  rerr;
  logic [POW_W-1:0]      pw;
  logic [TRIAL_W-1:0]    k;
  logic [PROD_W-1:0]     prod, prod_rnd;
  logic [CHI_W-1:0]      e, chi, term;
  logic [STATUS_W-1:0]   status;

  logic                  ram_we;
  logic [CIDX-1:0]       ram_raddr;
  logic [COUNT_BITS-1:0] rdata, cnt_old, cnt_inc, obs_cnt;
  logic                  div_start, div_done;
  logic [DIV_DEN_W-1:0]  div_den, den_rec;
  logic [DIV_NUM_W-1:0]  div_quo;
  logic [CHI_W-1:0]      quo_sat;
  logic [Q_W-1:0]        q;
  logic [FACT_W-1:0]     factor;
  logic [DIFF_W-1:0]     obs, diff;
  logic [CHI_W:0]        chi_sum;
  logic [CW-1:0]         cells;
  logic [QIDX_W-1:0]     qidx;
  logic [CMP_W-1:0]      cmp_lhs, cmp_rhs;
  logic                  pass;
  logic [STATUS_W-1:0]   pre_status;

  assign {e_cell, e_inr, e_last, e_largest, e_n, e_rerr} = q_data;

  csq_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_CELLS)) u_hist (
    .clk(clk), .we(ram_we), .waddr(b_cell), .wdata(cnt_inc),
    .raddr(ram_raddr), .rdata(rdata)
  );

  csq_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(prod[DIV_NUM_W-1:0]),
    .den(div_den), .done(div_done), .quo(div_quo)
  );

  always_comb begin
    cnt_old  = (fwd_valid && fwd_addr == b_cell) ? fwd_data
             : (cnt_valid[b_cell] ? rdata : '0);
    cnt_inc  = (&cnt_old) ? cnt_old : cnt_old + 1'b1;
    obs_cnt  = cnt_valid[i] ? rdata : '0;
    q        = Q_W'(1 << FRAC_W) - Q_W'(cfg.prob);
    if (cfg.mode[0]) begin
      factor  = FACT_W'(i) + FACT_W'(cfg.trial) - 1'b1;
      den_rec = DIV_DEN_W'(i) << FRAC_W;
    end else begin
      factor  = (FACT_W'(i) <= FACT_W'(cfg.trial))
              ? FACT_W'(cfg.trial) - FACT_W'(i) + 1'b1 : '0;
      den_rec = DIV_DEN_W'(q) * DIV_DEN_W'(i);
    end
    quo_sat  = (|div_quo[DIV_NUM_W-1:CHI_W]) ? SAT32 : div_quo[CHI_W-1:0];
    prod_rnd = (prod + PROD_W'(ROUND_HALF)) >> FRAC_W;
    obs      = DIFF_W'(obs_cnt) << FRAC_W;
    diff     = (obs > DIFF_W'(e)) ? obs - DIFF_W'(e) : DIFF_W'(e) - obs;
    chi_sum  = (CHI_W + 1)'(chi) + (CHI_W + 1)'(term);
    cells    = CW'(largest) + 1'b1;
    qidx     = QIDX_W'(int'(largest) - 1);
    cmp_lhs  = (CMP_W'(chi) + 1'b1) * CMP_W'(QUANT_SCALE);
    cmp_rhs  = (CMP_W'(QUANT_E4[qidx]) << FRAC_W) + CMP_W'(QUANT_ROUND);
    pass     = (status == FIT_OK) && (cmp_lhs <= cmp_rhs);
    if (rerr) begin
      pre_status = FIT_RANGE;
    end else if (largest == '0) begin
      pre_status = FIT_FEW_CELLS;
    end else if ((int'(largest) - 1 >= QUANTILE_ENTRIES) ||
                 (int'(largest) - 1 >= QUANT_DEPTH)) begin
      pre_status = FIT_RANGE;
    end else begin
      pre_status = FIT_OK;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:    if (b_valid && b_last) state_next = ST_SETTLE;
      ST_SETTLE:  state_next = (pre_status != FIT_OK) ? ST_DONE : ST_POW;
      ST_POW:     state_next = (k == cfg.trial) ? ST_E0 : ST_POW_RND;
      ST_POW_RND: state_next = ST_POW;
      ST_E0:      state_next = ST_E0_RND;
      ST_E0_RND:  state_next = ST_ECHK;
      ST_ECHK:    state_next = (e == '0) ? ST_DONE : ST_OBS;
      ST_OBS:     state_next = (diff > DIFF_W'(SAT32)) ? ST_ACC : ST_TSTART;
      ST_TSTART:  state_next = ST_TWAIT;
      ST_TWAIT:   if (div_done) state_next = ST_ACC;
      ST_ACC:     state_next = (i == largest) ? ST_DONE : ST_MUL_F;
      ST_MUL_F:   state_next = ST_MUL_P;
      ST_MUL_P:   state_next = ST_ESTART;
      ST_ESTART:  state_next = ST_EWAIT;
      ST_EWAIT:   if (div_done) state_next = ST_ECHK;
      ST_DONE:    if (!out_ch.valid || out_ch.ready) state_next = ST_LOAD;
      default:    state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    q_pop     = (state == ST_LOAD) && !q_empty && !(b_valid && b_last);
    ram_we    = b_valid && b_inr;
    ram_raddr = (state == ST_LOAD) ? e_cell : i;
    div_start = (state == ST_TSTART) || (state == ST_ESTART);
    div_den   = (state == ST_TSTART) ? e : den_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      b_valid      <= 1'b0;
      fwd_valid    <= 1'b0;
      cnt_valid    <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_LOAD) begin
        b_valid <= q_pop;
      end else begin
        b_valid <= 1'b0;
      end
      fwd_valid <= ram_we;
      if (ram_we) begin
        cnt_valid[b_cell] <= 1'b1;
      end
      if (state == ST_DONE && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
        cnt_valid    <= '0;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_cell    <= e_cell;
      b_inr     <= e_inr;
      b_last    <= e_last;
      b_largest <= e_largest;
      b_n       <= e_n;
      b_rerr    <= e_rerr;
    end
    if (ram_we) begin
      fwd_addr <= b_cell;
      fwd_data <= cnt_inc;
    end
    case (state)
      ST_LOAD: begin
        if (b_valid && b_last) begin
          largest <= b_largest;
          n_samp  <= b_n;
          rerr    <= b_rerr;
        end
      end
      ST_SETTLE: begin
        status <= pre_status;
        pw     <= POW_W'(1) << CHI_W;
        k      <= '0;
        chi    <= '0;
        i      <= '0;
      end
      ST_POW:     prod <= PROD_W'(pw) * PROD_W'(q);
      ST_POW_RND: begin
        pw <= POW_W'(prod_rnd);
        k  <= k + 1'b1;
      end
      ST_E0:      prod <= PROD_W'(n_samp) * PROD_W'(pw);
      ST_E0_RND:  e <= (|prod_rnd[PROD_W-1:CHI_W]) ? SAT32 : prod_rnd[CHI_W-1:0];
      ST_ECHK:    if (e == '0) status <= FIT_ZERO_EXP;
      ST_OBS: begin
        if (diff > DIFF_W'(SAT32)) begin
          term <= SAT32;
        end else begin
          prod <= PROD_W'(diff[CHI_W-1:0]) * PROD_W'(diff[CHI_W-1:0]);
        end
      end
      ST_TWAIT:   if (div_done) term <= quo_sat;
      ST_ACC: begin
        chi <= chi_sum[CHI_W] ? SAT32 : chi_sum[CHI_W-1:0];
        if (i != largest) i <= i + 1'b1;
      end
      ST_MUL_F:   prod <= PROD_W'(e) * PROD_W'(factor);
      ST_MUL_P:   prod <= prod * PROD_W'(cfg.prob);
      ST_EWAIT:   if (div_done) e <= quo_sat;
      ST_DONE: begin
        if (!out_ch.valid || out_ch.ready) begin
          out_ch.test_pass     <= pass;
          out_ch.chi_statistic <= (status == FIT_OK) ? chi : '0;
          out_ch.cell_total    <= CELLTOT_W'(cells);
          out_ch.fit_status    <= status;
        end
      end
      default: ;
    endcase
  end
endmodule

// File: rtl/chi_square_discrete_fit_test_unit.sv
// Pearson chi-square goodness-of-fit unit against binomial / negative binomial counts.
// Usage:
//   samples: valid/ready channel, one sample_value per item, last_sample closes a set.
//   results: valid/ready channel, one item per set (test_pass, chi_statistic,
//            cell_total, fit_status).
//   cfg_we/cfg_index/cfg_data: register writes (0 mode, 1 p in Q0.16, 2 r); the user
//            must make them only while the unit is idle; the unit does not enforce this.
// Samples are taken one per cycle while the 4-entry queue is not full; the
// histogram RMW in the back end retires one item per cycle while it loads a set.
// At the end of a set the back end evaluates (1-p)^r and cell 0, then each cell
// in turn, using the shared 64-step bit-serial divider (up to two divisions per cell).
// While evaluating, the queue fills and then holds off further samples.
// Reset: registers return to mode 0, p = 0.5, r = 1; histogram and set state clear.
// A stalled results receiver holds the result register; the back end waits
// with the next result but the queue keeps taking samples until full.
// Depends on csq_pkg, csq_if, csq_fifo, csq_front, csq_back.
`timescale 1ns / 1ps
module chi_square_discrete_fit_test_unit import csq_pkg::*; #(
  parameter int MAX_CELLS        = DEF_MAX_CELLS,
  parameter int QUANTILE_ENTRIES = DEF_QUANTILE_ENTRIES,
  parameter int COUNT_BITS       = DEF_COUNT_BITS,
  localparam int CIDX    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1,
  localparam int ENTRY_W = 2 * CIDX + COUNT_BITS + 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  csq_in_if.sink                samples,
  csq_out_if.source             results
);
  cfg_t               cfg;
  logic               push, full, pop, empty;
  logic [ENTRY_W-1:0] push_data, pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode  <= '0;
      cfg.prob  <= PROB_W'(32768);
      cfg.trial <= TRIAL_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:  cfg.mode  <= cfg_data[MODE_W-1:0];
        CFG_PROB:  cfg.prob  <= cfg_data[PROB_W-1:0];
        CFG_TRIAL: cfg.trial <= cfg_data[TRIAL_W-1:0];
        default: ;
      endcase
    end
  end

  csq_front #(.MAX_CELLS(MAX_CELLS), .COUNT_BITS(COUNT_BITS)) u_front (
    .clk(clk), .rst(rst), .in_ch(samples), .push(push), .push_data(push_data), .full(full)
  );

  csq_fifo #(.WIDTH(ENTRY_W), .DEPTH(4)) u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(push_data), .full(full),
    .pop(pop), .rdata(pop_data), .empty(empty)
  );

  csq_back #(
    .MAX_CELLS(MAX_CELLS), .QUANTILE_ENTRIES(QUANTILE_ENTRIES), .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_empty(empty), .q_data(pop_data),
    .q_pop(pop), .out_ch(results)
  );
endmodule
